/* rtl/core/cttr_pkg.sv */
`default_nettype none

package cttr_pkg;

    // Field widths
    localparam int unsigned REG_W      = 7;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ACT_W      = 2;
    localparam int unsigned DIR_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned OUT_DATA_W = 16;

    // Input kinds
    localparam logic KIND_CLICK = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // Result actions
    localparam logic [ACT_W-1:0] ACT_SELECT   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEND     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_DESELECT = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REPORT   = 2'd3;

    // Turn directions
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // Read positions within one sweep
    localparam logic [1:0] POS_CLICK = 2'd0;
    localparam logic [1:0] POS_X     = 2'd1;
    localparam logic [1:0] POS_Y     = 2'd2;
    localparam logic [1:0] POS_Z     = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_ADDR      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_ADDR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_ADDR      = 3'd5;

    // Configuration reset values
    localparam logic [REG_W-1:0] RST_THRESHOLD_X = 7'd32;
    localparam logic [REG_W-1:0] RST_THRESHOLD_Y = 7'd32;
    localparam logic [REG_W-1:0] RST_CLICK_ADDR  = 7'd57;
    localparam logic [REG_W-1:0] RST_X_ADDR      = 7'd41;
    localparam logic [REG_W-1:0] RST_Y_ADDR      = 7'd43;
    localparam logic [REG_W-1:0] RST_Z_ADDR      = 7'd45;

    // Read command flag on the address byte
    localparam logic READ_FLAG = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'b001,
        PH_ADDR_SENT  = 3'b010,
        PH_DUMMY_SENT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [BYTE_W-1:0] tx_byte;
        logic [DIR_W-1:0]  direction;
        logic              last;
    } result_beat_t;

endpackage

`default_nettype wire

/* rtl/core/click_triggered_tilt_reader_core.sv */
// Click-triggered tilt reader. Input beats are either a click interrupt
// (tuser 0) or a byte received on the serial link (tuser 1, byte in tdata).
// A click while idle starts a sweep over four sensor registers (click source,
// X, Y, Z); each read produces a select+address beat, a dummy-send beat after
// the next received byte, and a deselect beat after the answer byte. At the
// end of the Z read the block may add a direction report (tuser 3) when X or
// Y exceeds its threshold. Each input beat yields zero, one or two output
// beats, the final one flagged by tlast. Timing: an accepted beat is held in
// the input register and is then resolved combinationally into a two-slot
// result buffer, so the block takes one beat per clock as long as the output
// does not stall and each beat yields at most one result; a beat that yields
// two results holds the input side while the second result drains from the
// buffer. While a result waits on a stalled output, the input register still
// takes one more beat; a held beat that yields no result is dropped at once,
// any other waits there until the buffer frees. Thresholds and register
// addresses are to be written by the user through the cfg port while the block
// is idle; the block does not enforce it. There is no clearing pass after reset.
`default_nettype none

module click_triggered_tilt_reader_core
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_we,
    input  wire logic [cttr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [cttr_pkg::REG_W-1:0]        cfg_data,

    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    input  wire logic [cttr_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
    input  wire logic                              s_axis_tuser,   // [0] kind

    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output      logic [cttr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] tx_byte, [9:8] direction
    output      logic [cttr_pkg::ACT_W-1:0]        m_axis_tuser,   // [1:0] action
    output      logic                              m_axis_tlast
);

    import cttr_pkg::*;

    // Configuration registers
    logic [REG_W-1:0] threshold_x_reg;
    logic [REG_W-1:0] threshold_y_reg;
    logic [REG_W-1:0] click_addr_reg;
    logic [REG_W-1:0] x_addr_reg;
    logic [REG_W-1:0] y_addr_reg;
    logic [REG_W-1:0] z_addr_reg;

    // Input register
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // Sweep state
    phase_t            phase_reg, phase_next;
    logic [1:0]        pos_reg, pos_next;
    logic [BYTE_W-1:0] x_sample_reg, x_sample_next;
    logic [BYTE_W-1:0] y_sample_reg, y_sample_next;

    // Result buffer: up to two beats, head selects which one is on the port
    result_beat_t beat0_reg, beat1_reg;
    logic [1:0]   count_reg;
    logic         head_reg;

    // Resolution of the held beat
    result_beat_t res0, res1;
    logic [1:0]   res_count;
    logic [1:0]   sel_pos;
    logic [REG_W-1:0] sel_addr;
    logic [BYTE_W-1:0] abs_x, abs_y;
    logic         tilt_hit;
    logic [DIR_W-1:0] tilt_dir;

    logic         out_fire;
    logic         buf_free;
    logic         load;
    result_beat_t cur_beat;

    //--------------------------------------------------------------------
    // Configuration writes
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_x_reg <= RST_THRESHOLD_X;
            threshold_y_reg <= RST_THRESHOLD_Y;
            click_addr_reg  <= RST_CLICK_ADDR;
            x_addr_reg      <= RST_X_ADDR;
            y_addr_reg      <= RST_Y_ADDR;
            z_addr_reg      <= RST_Z_ADDR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD_X: threshold_x_reg <= cfg_data;
                CFG_THRESHOLD_Y: threshold_y_reg <= cfg_data;
                CFG_CLICK_ADDR:  click_addr_reg  <= cfg_data;
                CFG_X_ADDR:      x_addr_reg      <= cfg_data;
                CFG_Y_ADDR:      y_addr_reg      <= cfg_data;
                CFG_Z_ADDR:      z_addr_reg      <= cfg_data;
                default:         ;  // unmapped index: drop the write
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Handshake control
    //--------------------------------------------------------------------
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    // The buffer can take a new set of results when it is empty or its
    // last beat leaves this cycle.
    assign buf_free      = (count_reg == 2'd0) || ((count_reg == 2'd1) && m_axis_tready);
    // A beat with no results never waits on the buffer.
    assign load          = in_valid_reg && ((res_count == 2'd0) || buf_free);
    assign s_axis_tready = !in_valid_reg || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_kind_reg <= s_axis_tuser;
            in_byte_reg <= s_axis_tdata;
        end
    end

    //--------------------------------------------------------------------
    // Tilt test on stored X and Y; -128 has magnitude 128
    //--------------------------------------------------------------------
    always_comb
    begin
        abs_x = x_sample_reg[BYTE_W-1] ? (~x_sample_reg + 8'd1) : x_sample_reg;
        abs_y = y_sample_reg[BYTE_W-1] ? (~y_sample_reg + 8'd1) : y_sample_reg;
        // |v| > t covers both v > t and v < -t
        tilt_hit = (abs_x > {1'b0, threshold_x_reg}) || (abs_y > {1'b0, threshold_y_reg});
        if (abs_x > abs_y)
        begin
            tilt_dir = x_sample_reg[BYTE_W-1] ? DIR_UP : DIR_DOWN;
        end
        else
        begin
            // ties go to Y; a zero Y counts as not positive
            tilt_dir = (!y_sample_reg[BYTE_W-1] && (y_sample_reg != '0)) ? DIR_LEFT
                                                                          : DIR_RIGHT;
        end
    end

    //--------------------------------------------------------------------
    // Address of the register to read next
    //--------------------------------------------------------------------
    always_comb
    begin
        sel_pos = (in_kind_reg == KIND_CLICK) ? POS_CLICK : (pos_reg + 2'd1);
        unique case (sel_pos)
            POS_CLICK: sel_addr = click_addr_reg;
            POS_X:     sel_addr = x_addr_reg;
            POS_Y:     sel_addr = y_addr_reg;
            default:   sel_addr = z_addr_reg;
        endcase
    end

    //--------------------------------------------------------------------
    // Resolve the held beat into results and next state
    //--------------------------------------------------------------------
    always_comb
    begin
        res0          = '0;
        res1          = '0;
        res_count     = 2'd0;
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        x_sample_next = x_sample_reg;
        y_sample_next = y_sample_reg;

        if (in_kind_reg == KIND_CLICK)
        begin
            // click while busy: drop
            if (phase_reg == PH_IDLE)
            begin
                pos_next   = POS_CLICK;
                res0       = '{action: ACT_SELECT, tx_byte: {READ_FLAG, sel_addr},
                               direction: DIR_DOWN, last: 1'b1};
                res_count  = 2'd1;
                phase_next = PH_ADDR_SENT;
            end
        end
        else if (phase_reg == PH_ADDR_SENT)
        begin
            // received byte is don't-care; send the dummy byte
            res0       = '{action: ACT_SEND, tx_byte: '0, direction: DIR_DOWN, last: 1'b1};
            res_count  = 2'd1;
            phase_next = PH_DUMMY_SENT;
        end
        else if (phase_reg == PH_DUMMY_SENT)
        begin
            if (pos_reg == POS_X)
            begin
                x_sample_next = in_byte_reg;
            end
            if (pos_reg == POS_Y)
            begin
                y_sample_next = in_byte_reg;
            end
            res0 = '{action: ACT_DESELECT, tx_byte: '0, direction: DIR_DOWN, last: 1'b1};
            if (pos_reg == POS_Z)
            begin
                // end of sweep: back to idle, report a tilt if any
                pos_next   = POS_CLICK;
                phase_next = PH_IDLE;
                if (tilt_hit)
                begin
                    res0.last = 1'b0;
                    res1      = '{action: ACT_REPORT, tx_byte: '0,
                                  direction: tilt_dir, last: 1'b1};
                    res_count = 2'd2;
                end
                else
                begin
                    res_count = 2'd1;
                end
            end
            else
            begin
                // deselect, then start the next read at once
                pos_next   = sel_pos;
                phase_next = PH_ADDR_SENT;
                res0.last  = 1'b0;
                res1       = '{action: ACT_SELECT, tx_byte: {READ_FLAG, sel_addr},
                               direction: DIR_DOWN, last: 1'b1};
                res_count  = 2'd2;
            end
        end
        // byte while idle: drop
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            pos_reg      <= POS_CLICK;
            x_sample_reg <= '0;
            y_sample_reg <= '0;
        end
        else if (load)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            x_sample_reg <= x_sample_next;
            y_sample_reg <= y_sample_next;
        end
    end

    //--------------------------------------------------------------------
    // Result buffer
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            head_reg  <= 1'b0;
        end
        else if (load && (res_count != 2'd0))
        begin
            count_reg <= res_count;
            head_reg  <= 1'b0;
        end
        else if (out_fire)
        begin
            // advance to the second beat or go empty
            count_reg <= count_reg - 2'd1;
            head_reg  <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && (res_count != 2'd0))
        begin
            beat0_reg <= res0;
            beat1_reg <= res1;
        end
    end

    assign cur_beat      = head_reg ? beat1_reg : beat0_reg;
    assign m_axis_tuser  = cur_beat.action;
    assign m_axis_tdata  = {{(OUT_DATA_W - BYTE_W - DIR_W){1'b0}},
                            cur_beat.direction, cur_beat.tx_byte};
    assign m_axis_tlast  = cur_beat.last;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    // A direction report always closes the results of its input beat.
    a_report_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ACT_REPORT)) |-> m_axis_tlast)
        else $error("direction report without tlast");

    // Every select beat carries the read flag on its address byte.
    a_select_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == ACT_SELECT)) |-> m_axis_tdata[BYTE_W-1])
        else $error("select beat without read flag");

    // A buffered pair has its first beat open and its second beat closing.
    a_pair_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd2) |-> (!head_reg && !beat0_reg.last && beat1_reg.last))
        else $error("result pair malformed");

    // Ending a sweep always returns to idle at the click-source position.
    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (phase_reg == PH_DUMMY_SENT) && (pos_reg == POS_Z)
         && (in_kind_reg == KIND_BYTE))
        |=> ((phase_reg == PH_IDLE) && (pos_reg == POS_CLICK)))
        else $error("sweep did not return to idle");

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import cttr_pkg::*;

    // Settle time after the last expected beat: covers the input register, the
    // resolve step, the two buffer slots, plus margin.
    localparam int SETTLE_CYCLES = 8;
    // Cycles without any handshake on either side before the run is abandoned.
    localparam int QUIET_LIMIT   = 2000;
    // Rough number of beats queued per configured phase.
    localparam int PHASE_ITEMS   = 215;
    localparam int NUM_PHASES    = 5;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] rx;
    } sensor_event_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESHOLD_X;
    logic [REG_W-1:0]      cfg_data = '0;

    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [BYTE_W-1:0]     s_axis_tdata = '0;   // [7:0] rx_byte
    logic                  s_axis_tuser = KIND_CLICK;   // [0] kind

    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [7:0] tx_byte, [9:8] direction
    logic [ACT_W-1:0]      m_axis_tuser;   // [1:0] action
    logic                  m_axis_tlast;

    click_triggered_tilt_reader_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: configuration registers and sweep state.
    // ------------------------------------------------------------------
    logic [REG_W-1:0]  thr_x     = RST_THRESHOLD_X;
    logic [REG_W-1:0]  thr_y     = RST_THRESHOLD_Y;
    logic [REG_W-1:0]  addr_src  = RST_CLICK_ADDR;
    logic [REG_W-1:0]  addr_x    = RST_X_ADDR;
    logic [REG_W-1:0]  addr_y    = RST_Y_ADDR;
    logic [REG_W-1:0]  addr_z    = RST_Z_ADDR;

    phase_t            sweep_phase = PH_IDLE;
    logic [1:0]        sweep_pos   = POS_CLICK;
    logic [BYTE_W-1:0] samples [4] = '{default: '0};

    sensor_event_t     event_q[$];      // beats waiting for the driver
    result_beat_t      spi_due[$];      // beats the block still owes us

    int                mismatches   = 0;
    int                queued_items = 0;
    int                bytes_to_idle = 0;   // generator's view of the sweep in progress

    // Read command byte for the register at a sweep position.
    function automatic logic [BYTE_W-1:0] read_command(input logic [1:0] pos);
        logic [REG_W-1:0] a;
        case (pos)
            POS_CLICK: a = addr_src;
            POS_X:     a = addr_x;
            POS_Y:     a = addr_y;
            default:   a = addr_z;
        endcase
        return {READ_FLAG, a};
    endfunction

    // Advance the shadow on one accepted beat and queue the beats it owes.
    function automatic void predict_event(input logic kind, input logic [BYTE_W-1:0] rx);
        result_beat_t beats [2];
        int           n;
        int           sx;
        int           sy;
        int           ax;
        int           ay;
        logic         busy;
        n    = 0;
        busy = (sweep_phase == PH_ADDR_SENT) || (sweep_phase == PH_DUMMY_SENT);
        if (kind == KIND_CLICK)
        begin
            // A click during a sweep is dropped.
            if (!busy)
            begin
                sweep_pos   = POS_CLICK;
                beats[n]    = '{ACT_SELECT, read_command(POS_CLICK), DIR_DOWN, 1'b0};
                n++;
                sweep_phase = PH_ADDR_SENT;
            end
        end
        else if (busy)
        begin
            if (sweep_phase == PH_ADDR_SENT)
            begin
                // Byte clocked in with the address is junk; send the dummy.
                beats[n]    = '{ACT_SEND, 8'h00, DIR_DOWN, 1'b0};
                n++;
                sweep_phase = PH_DUMMY_SENT;
            end
            else
            begin
                samples[sweep_pos] = rx;
                beats[n] = '{ACT_DESELECT, 8'h00, DIR_DOWN, 1'b0};
                n++;
                if (sweep_pos == POS_Z)
                begin
                    sweep_pos   = POS_CLICK;
                    sweep_phase = PH_IDLE;
                    sx = int'($signed(samples[POS_X]));
                    sy = int'($signed(samples[POS_Y]));
                    if (sx > int'(thr_x) || sx < -int'(thr_x) ||
                        sy > int'(thr_y) || sy < -int'(thr_y))
                    begin
                        ax = (sx < 0) ? -sx : sx;
                        ay = (sy < 0) ? -sy : sy;
                        beats[n] = '{ACT_REPORT, 8'h00,
                                     (ax > ay) ? ((sx > 0) ? DIR_DOWN : DIR_UP)
                                               : ((sy > 0) ? DIR_LEFT : DIR_RIGHT),
                                     1'b0};
                        n++;
                    end
                end
                else
                begin
                    sweep_pos   = sweep_pos + 2'd1;
                    beats[n]    = '{ACT_SELECT, read_command(sweep_pos), DIR_DOWN, 1'b0};
                    n++;
                    sweep_phase = PH_ADDR_SENT;
                end
            end
        end
        for (int i = 0; i < n; i++)
        begin
            beats[i].last = (i == n - 1);
            spi_due.push_back(beats[i]);
        end
    endfunction

    function automatic void check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: pop pending beats in bursts, with random gaps between them.
    // ------------------------------------------------------------------
    sensor_event_t next_event;
    int            burst_left = 1;
    int            gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= KIND_CLICK;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            // Current beat taken (or none offered): pick what to show next.
            if (gap_left > 0)
            begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                next_event    = event_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= next_event.rx;
                s_axis_tuser  <= next_event.kind;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: back-pressure in windows of one mode each - always ready,
    // coin flip, one cycle in three, or long stalls.
    // ------------------------------------------------------------------
    int stall_mode   = 0;
    int stall_window = 0;
    int stall_tick   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (stall_window == 0)
            begin
                stall_mode   = $urandom_range(0, 3);
                stall_window = $urandom_range(16, 96);
            end
            stall_window--;
            stall_tick++;
            case (stall_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= (stall_tick % 3 == 0);
                default: m_axis_tready <= (stall_tick % 9 == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every accepted input beat, check every output
    // beat against the oldest owed beat, and watch for a hang.
    // ------------------------------------------------------------------
    result_beat_t owed;
    int           quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (spi_due.size() == 0)
                begin
                    $display("%0t: unexpected beat: expected none, actual action %0d tdata %04h last %0b",
                             $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    owed = spi_due.pop_front();
                    check_field("action", owed.action, m_axis_tuser);
                    check_field("tx_byte", owed.tx_byte, m_axis_tdata[7:0]);
                    check_field("direction", owed.direction, m_axis_tdata[9:8]);
                    check_field("tdata padding", 0, m_axis_tdata[OUT_DATA_W-1:10]);
                    check_field("last", owed.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_event(s_axis_tuser, s_axis_tdata);

            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Queue one beat and track how far the sweep it belongs to has got.
    task automatic push_event(input logic kind, input logic [BYTE_W-1:0] rx);
        event_q.push_back(sensor_event_t'{kind, rx});
        queued_items++;
        if (kind == KIND_CLICK && bytes_to_idle == 0)
            bytes_to_idle = 8;
        else if (kind == KIND_BYTE && bytes_to_idle > 0)
            bytes_to_idle--;
    endtask

    // One click and the eight bytes of a full sweep; optionally slip in
    // clicks that the block has to drop.
    task automatic push_sweep(input logic [BYTE_W-1:0] src, input logic [BYTE_W-1:0] x,
                              input logic [BYTE_W-1:0] y, input logic [BYTE_W-1:0] z,
                              input logic noisy);
        logic [BYTE_W-1:0] answers [4];
        answers = '{src, x, y, z};
        push_event(KIND_CLICK, BYTE_W'($urandom_range(0, 255)));
        for (int i = 0; i < 4; i++)
        begin
            if (noisy && $urandom_range(0, 5) == 0)
                push_event(KIND_CLICK, BYTE_W'($urandom_range(0, 255)));
            push_event(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
            push_event(KIND_BYTE, answers[i]);
        end
    endtask

    // Axis value biased to the threshold edges and the ends of the range.
    function automatic logic [BYTE_W-1:0] pick_axis(input logic [REG_W-1:0] thr);
        logic [BYTE_W-1:0] t;
        t = {1'b0, thr};
        case ($urandom_range(0, 7))
            0:       return t;
            1:       return t + 8'd1;
            2:       return 8'd0 - t;
            3:       return ~t;
            4:       return 8'h80;
            5:       return 8'h7F;
            6:       return 8'h00;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly clean sweeps with random content; the rest loose beats and
    // half-finished sweeps.
    task automatic fill_phase(input int target);
        int                first;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        first = queued_items;
        while (queued_items - first < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    push_event(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
            end
            else
            begin
                // Finish off whatever the noise left open.
                if (bytes_to_idle > 0 && $urandom_range(0, 1) == 0)
                    while (bytes_to_idle > 0)
                        push_event(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
                x = pick_axis(thr_x);
                if ($urandom_range(0, 4) == 0)
                    y = $urandom_range(0, 1) ? x : 8'd0 - x;   // equal magnitudes
                else
                    y = pick_axis(thr_y);
                push_sweep(BYTE_W'($urandom_range(0, 255)), x, y,
                           BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
        end
        // Leave the block idle so the next configuration lands between sweeps.
        while (bytes_to_idle > 0)
            push_event(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
    endtask

    // Wait until every beat is in and every owed beat is out, then let
    // anything still in the pipe settle.
    task automatic drain_block();
        do
            @(negedge clk);
        while (event_q.size() != 0 || s_axis_tvalid || spi_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_THRESHOLD_X: thr_x    = val;
            CFG_THRESHOLD_Y: thr_y    = val;
            CFG_CLICK_ADDR:  addr_src = val;
            CFG_X_ADDR:      addr_x   = val;
            CFG_Y_ADDR:      addr_y   = val;
            CFG_Z_ADDR:      addr_z   = val;
            default:         ;
        endcase
    endtask

    task automatic set_config(input logic [REG_W-1:0] tx, input logic [REG_W-1:0] ty,
                              input logic [REG_W-1:0] a_src, input logic [REG_W-1:0] a_x,
                              input logic [REG_W-1:0] a_y, input logic [REG_W-1:0] a_z);
        write_cfg_reg(CFG_THRESHOLD_X, tx);
        write_cfg_reg(CFG_THRESHOLD_Y, ty);
        write_cfg_reg(CFG_CLICK_ADDR, a_src);
        write_cfg_reg(CFG_X_ADDR, a_x);
        write_cfg_reg(CFG_Y_ADDR, a_y);
        write_cfg_reg(CFG_Z_ADDR, a_z);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed, reset configuration. Bytes while idle are dropped.
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_BYTE, 8'h00);
        // Sweep by hand: two more clicks land mid-sweep and are dropped, the
        // byte after each address is junk, X is -128 and Y is 127, so X wins
        // on magnitude and points up.
        push_event(KIND_CLICK, 8'h00);
        push_event(KIND_CLICK, 8'hFF);
        push_event(KIND_BYTE, 8'hAA);
        push_event(KIND_BYTE, 8'hFF);
        push_event(KIND_BYTE, 8'h55);
        push_event(KIND_CLICK, 8'h00);
        push_event(KIND_BYTE, 8'h80);
        push_event(KIND_BYTE, 8'h00);
        push_event(KIND_BYTE, 8'h7F);
        push_event(KIND_BYTE, 8'h01);
        push_event(KIND_BYTE, 8'h00);
        // Equal magnitudes go to Y; negative Y turns right.
        push_sweep(8'h00, 8'h7F, 8'h81, 8'hFF, 1'b0);
        drain_block();

        // Walk through threshold and address extremes, then random settings.
        for (int p = 1; p <= NUM_PHASES; p++)
        begin
            case (p)
                1: set_config(7'd0, 7'd0, 7'd0, 7'd127, 7'd1, 7'd126);
                2: set_config(7'd127, 7'd127, 7'd127, 7'd0, 7'd126, 7'd1);
                3: set_config(7'd5, 7'd100, REG_W'($urandom_range(0, 127)),
                              REG_W'($urandom_range(0, 127)), REG_W'($urandom_range(0, 127)),
                              REG_W'($urandom_range(0, 127)));
                default: set_config(REG_W'($urandom_range(0, 127)),
                                    REG_W'($urandom_range(0, 127)),
                                    REG_W'($urandom_range(0, 127)),
                                    REG_W'($urandom_range(0, 127)),
                                    REG_W'($urandom_range(0, 127)),
                                    REG_W'($urandom_range(0, 127)));
            endcase
            fill_phase(PHASE_ITEMS);
            drain_block();
        end

        if (mismatches == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/cttr_pkg.sv
rtl/core/click_triggered_tilt_reader_core.sv
test/testbench.sv
